@@ sv/rpp_pkg.sv @@
// Shared types and constants for the rotated pixel plot frame store.
package rpp_pkg;

  localparam int unsigned COLS_W = 7;
  localparam int unsigned PAGE_W = 3;
  localparam int unsigned ROW_W  = 6;
  localparam int unsigned ADDR_W = PAGE_W + COLS_W;

  // operation codes
  localparam logic [1:0] OP_DRAW  = 2'd0;
  localparam logic [1:0] OP_READ  = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // pen codes (anything else clears)
  localparam logic [1:0] PEN_CLR = 2'd0;
  localparam logic [1:0] PEN_SET = 2'd1;
  localparam logic [1:0] PEN_INV = 2'd2;

  // rotation codes
  localparam logic [1:0] ROT_0   = 2'd0;
  localparam logic [1:0] ROT_90  = 2'd1;
  localparam logic [1:0] ROT_180 = 2'd2;
  localparam logic [1:0] ROT_270 = 2'd3;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [1:0] pen;
    logic [2:0] read_page;
    logic [6:0] read_column;
  } in_item_t;

  typedef struct packed {
    logic [2:0] page;
    logic [6:0] column;
    logic [7:0] byte_value;
    logic       in_bounds;
  } out_item_t;

  typedef enum logic [1:0] {
    CMD_DRAW,
    CMD_READ,
    CMD_CLEAR,
    CMD_NOP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t         kind;
    logic [ADDR_W-1:0] addr;
    logic [2:0]        bit_sel;
    logic [1:0]        pen;
  } cmd_t;

  typedef enum logic [2:0] {
    ST_INIT,
    ST_IDLE,
    ST_ACCESS,
    ST_CLEAR,
    ST_RESP
  } back_state_t;

endpackage

@@ sv/rpp_front.sv @@
// Front end: rotation register, bounds check, coordinate mapping, command build.
module rpp_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  rpp_pkg::in_item_t in_data,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_wdata,
  input  logic              q_full,
  input  logic              init_busy,
  output logic              push,
  output rpp_pkg::cmd_t     push_cmd
);

  logic [1:0] rotation_r;
  logic [1:0] rotation_nxt;
  logic [7:0] x;
  logic [7:0] y;
  logic       inb;
  logic [rpp_pkg::COLS_W-1:0] col;
  logic [rpp_pkg::ROW_W-1:0]  row;

  assign rotation_nxt = cfg_we ? cfg_wdata : rotation_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rotation_r <= rpp_pkg::ROT_0;
    end else begin
      rotation_r <= rotation_nxt;
    end
  end

  assign in_ready = !q_full && !init_busy;
  assign push     = in_valid && in_ready;
  assign x        = in_data.pixel_x;
  assign y        = in_data.pixel_y;

  // sideways rotations swap the bounds
  always_comb begin
    if (rotation_r[0]) begin
      inb = (x[7:6] == 2'b00) && !y[7];
    end else begin
      inb = !x[7] && (y[7:6] == 2'b00);
    end
  end

  // coordinates are in bounds when used, so 127-v and 63-v are bit inversions
  always_comb begin
    unique case (rotation_r)
      rpp_pkg::ROT_90: begin
        col = ~y[6:0];
        row = x[5:0];
      end
      rpp_pkg::ROT_180: begin
        col = ~x[6:0];
        row = ~y[5:0];
      end
      rpp_pkg::ROT_270: begin
        col = y[6:0];
        row = ~x[5:0];
      end
      default: begin
        col = x[6:0];
        row = y[5:0];
      end
    endcase
  end

  always_comb begin
    push_cmd.kind    = rpp_pkg::CMD_NOP;
    push_cmd.addr    = {row[5:3], col};
    push_cmd.bit_sel = row[2:0];
    push_cmd.pen     = in_data.pen;
    unique case (in_data.operation)
      rpp_pkg::OP_DRAW: begin
        push_cmd.kind = inb ? rpp_pkg::CMD_DRAW : rpp_pkg::CMD_NOP;
      end
      rpp_pkg::OP_READ: begin
        push_cmd.kind = rpp_pkg::CMD_READ;
        push_cmd.addr = {in_data.read_page, in_data.read_column};
      end
      rpp_pkg::OP_CLEAR: begin
        push_cmd.kind = rpp_pkg::CMD_CLEAR;
      end
      default: begin
        push_cmd.kind = rpp_pkg::CMD_NOP;
      end
    endcase
  end

endmodule

@@ sv/rpp_queue.sv @@
// Two-entry command queue between front and back.
module rpp_queue (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  rpp_pkg::cmd_t push_cmd,
  output logic          full,
  input  logic          pop,
  output logic          valid,
  output rpp_pkg::cmd_t head
);

  rpp_pkg::cmd_t entry_r [2];
  logic          wr_ptr_r;
  logic          wr_ptr_nxt;
  logic          rd_ptr_r;
  logic          rd_ptr_nxt;
  logic [1:0]    count_r;
  logic [1:0]    count_nxt;

  assign full  = (count_r == 2'd2);
  assign valid = (count_r != 2'd0);
  assign head  = entry_r[rd_ptr_r];

  assign wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
  assign rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
  assign count_nxt  = count_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

@@ sv/rpp_back.sv @@
// Back end: frame store, read-modify-write sequencer, clear sweep, result register.
module rpp_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  rpp_pkg::cmd_t      q_head,
  output logic               q_pop,
  output logic               init_busy,
  output logic               out_valid,
  input  logic               out_ready,
  output rpp_pkg::out_item_t out_data
);

  logic [7:0] mem [1 << rpp_pkg::ADDR_W];

  rpp_pkg::back_state_t state_r;
  rpp_pkg::back_state_t state_nxt;
  logic [rpp_pkg::ADDR_W-1:0] clr_cnt_r;
  logic [rpp_pkg::ADDR_W-1:0] clr_cnt_nxt;
  logic                       clr_done;
  rpp_pkg::cmd_t              cur_r;
  logic [7:0]                 rd_data_r;
  logic                       out_valid_r;
  logic                       out_valid_nxt;
  rpp_pkg::out_item_t         out_data_r;

  logic                       out_free;
  logic                       rd_en;
  logic                       mem_we;
  logic [rpp_pkg::ADDR_W-1:0] mem_wa;
  logic [7:0]                 mem_wd;
  logic                       clr_step;
  logic                       out_load;
  rpp_pkg::out_item_t         out_load_data;
  logic [7:0]                 mask;
  logic [7:0]                 new_byte;

  assign out_free  = !out_valid_r || out_ready;
  assign clr_done  = (clr_cnt_r == {rpp_pkg::ADDR_W{1'b1}});
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign mask = 8'd1 << cur_r.bit_sel;

  always_comb begin
    case (cur_r.pen)
      rpp_pkg::PEN_SET: new_byte = rd_data_r | mask;
      rpp_pkg::PEN_INV: new_byte = rd_data_r ^ mask;
      default:          new_byte = rd_data_r & ~mask;
    endcase
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rpp_pkg::ST_INIT: begin
        if (clr_done) state_nxt = rpp_pkg::ST_IDLE;
      end
      rpp_pkg::ST_IDLE: begin
        if (q_valid) begin
          unique case (q_head.kind) inside
            rpp_pkg::CMD_DRAW, rpp_pkg::CMD_READ: state_nxt = rpp_pkg::ST_ACCESS;
            rpp_pkg::CMD_CLEAR:                   state_nxt = rpp_pkg::ST_CLEAR;
            default:                              state_nxt = rpp_pkg::ST_RESP;
          endcase
        end
      end
      rpp_pkg::ST_ACCESS: begin
        if (out_free) state_nxt = rpp_pkg::ST_IDLE;
      end
      rpp_pkg::ST_CLEAR: begin
        if (clr_done) state_nxt = rpp_pkg::ST_RESP;
      end
      rpp_pkg::ST_RESP: begin
        if (out_free) state_nxt = rpp_pkg::ST_IDLE;
      end
      default: state_nxt = rpp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    mem_we        = 1'b0;
    mem_wa        = clr_cnt_r;
    mem_wd        = 8'd0;
    clr_step      = 1'b0;
    out_load      = 1'b0;
    out_load_data = '0;
    init_busy     = 1'b0;
    unique case (state_r)
      rpp_pkg::ST_INIT: begin
        init_busy = 1'b1;
        mem_we    = 1'b1;
        clr_step  = 1'b1;
      end
      rpp_pkg::ST_IDLE: begin
        q_pop = q_valid;
        rd_en = q_valid;
      end
      rpp_pkg::ST_ACCESS: begin
        out_load                 = out_free;
        out_load_data.page       = cur_r.addr[rpp_pkg::ADDR_W-1 -: rpp_pkg::PAGE_W];
        out_load_data.column     = cur_r.addr[rpp_pkg::COLS_W-1:0];
        out_load_data.in_bounds  = (cur_r.kind == rpp_pkg::CMD_DRAW);
        out_load_data.byte_value = out_load_data.in_bounds ? new_byte : rd_data_r;
        mem_we                   = out_free && out_load_data.in_bounds;
        mem_wa                   = cur_r.addr;
        mem_wd                   = new_byte;
      end
      rpp_pkg::ST_CLEAR: begin
        mem_we   = 1'b1;
        clr_step = 1'b1;
      end
      rpp_pkg::ST_RESP: begin
        out_load = out_free;
      end
      default: begin
        init_busy = 1'b0;
      end
    endcase
  end

  assign clr_cnt_nxt   = clr_step ? clr_cnt_r + 1'b1 : clr_cnt_r;
  assign out_valid_nxt = out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rpp_pkg::ST_INIT;
      clr_cnt_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) cur_r <= q_head;
    if (out_load) out_data_r <= out_load_data;
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
  end

  always_ff @(posedge clk) begin
    if (rd_en) rd_data_r <= mem[q_head.addr];
  end

endmodule

@@ sv/rotated_pixel_plot_framebuffer.sv @@
// Path: an accepted draw or read item goes through a queue entry, the store read register
// and the result register; the back end takes a new item only after the read-modify-write
// of the frame store is done, and a clear item walks all 1024 bytes.
// Reset: synchronous, active low; afterwards a zeroing pass runs over all 1024 bytes of the store,
// in_ready stays low during it, and cfg writes are taken throughout. Rotation resets to none.
module rotated_pixel_plot_framebuffer (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  rpp_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output rpp_pkg::out_item_t out_data,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_wdata
);

  // front -> queue
  logic          push;
  rpp_pkg::cmd_t push_cmd;
  logic          q_full;
  // queue -> back
  logic          q_valid;
  logic          q_pop;
  rpp_pkg::cmd_t q_head;
  // back -> front: store is still being zeroed after reset
  logic          init_busy;

  // Front: classifies each item (bounds, rotation mapping) into a store command.
  rpp_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .init_busy (init_busy),
    .push      (push),
    .push_cmd  (push_cmd)
  );

  // Two-entry queue lets the front keep taking items while the back stalls.
  rpp_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .valid    (q_valid),
    .head     (q_head)
  );

  // Back: owns the 1024x8 store, does read-modify-write and the clear sweep,
  // and holds the result in an output register.
  rpp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (q_valid),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .init_busy (init_busy),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

@@ sv/rpp_checker.sv @@
// Port-level checker for the frame store block, bound to the top level.
module rpp_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input rpp_pkg::out_item_t out_data
);

  logic [2:0] pending_r;
  logic [2:0] pending_nxt;

  assign pending_nxt = pending_r + {2'b00, in_valid && in_ready}
                                 - {2'b00, out_valid && out_ready};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 3'd0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset starts the zeroing pass: no item taken, no result shown
  a_rst_busy: assert property (@(posedge clk)
    !rst_n |=> !in_ready && !out_valid)
    else $error("block not quiet after reset");

  // every result belongs to an accepted item
  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != 3'd0)
    else $error("result without an item");

  // queue plus back plus result register bound the items in flight
  a_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= 3'd4)
    else $error("too many items in flight");

endmodule

bind rotated_pixel_plot_framebuffer rpp_checker u_rpp_checker (.*);
